[rtl/core/bfha_pkg.sv]
// Shared types and codes for the best-fit heap allocator.
package bfha_pkg;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FAIL = 2'd1,
        ST_FULL = 2'd2,
        ST_NULL = 2'd3
    } t_status;

    typedef struct packed {
        logic        req_type;
        logic [15:0] req_size;
        logic [13:0] req_addr;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [13:0] grant_addr;
        logic [13:0] granted_bytes;
        logic [13:0] free_bytes;
    } t_rsp;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_AQ, S_AM, S_ACHK, S_FIT, S_CMP, S_BQ, S_ASPL, S_AFIN,
        S_FQ, S_FM, S_FCHK, S_FRD, S_REL, S_ADJ, S_MRG, S_INS, S_POS, S_SHF,
        S_PUT, S_FFIN, S_DONE
    } t_state;

endpackage

[rtl/core/bfha_ram.sv]
// Generic simple dual-port RAM with registered read.
module bfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

[rtl/core/best_fit_heap_allocator.sv]
// Best-fit heap allocator: one request in, one response out.
//
// Requests arrive on i_in_valid / o_in_stall with an allocate or free
// transaction in i_in_data; responses leave on o_out_valid / i_out_stall.
// Each request produces exactly one response carrying status, granted
// address, block size and the free byte count after the request.
// The free list lives in a MAX_FREE-entry RAM sorted by size; block sizes
// of granted blocks live in a second RAM indexed by start / ALIGN_BYTES.
// One request at a time. A null or short free address goes straight to the
// response; other requests pass through the divide and check states first,
// and a split allocate with merging then runs the free-list passes (fit
// search, compaction, merge search, a second compaction, insert search,
// shift), each walking the table RAM one entry per cycle.
// The response sits in an output register; a new request is taken while
// it waits, and a finished response waits in place while i_out_stall is
// high. Reset (synchronous, i_rst_n low) empties the free list to one
// block covering the usable heap; the first cycle after reset writes that
// entry, and requests are stalled meanwhile. i_cfg_we writes merge_enable
// and must be used only while the block is idle.
module best_fit_heap_allocator
    import bfha_pkg::*;
#(
    parameter int HEAP_BYTES   = 16384,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 8,
    parameter int MAX_FREE     = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data,
    input  logic i_cfg_we,
    input  logic i_cfg_data
);
    localparam int W   = $clog2(HEAP_BYTES) + 1;
    localparam int IW  = $clog2(MAX_FREE);
    localparam int CW  = $clog2(MAX_FREE + 1);
    localparam int SD  = HEAP_BYTES / ALIGN_BYTES;
    localparam int SIW = $clog2(SD);
    localparam int DN  = (W > 18) ? W : 18;
    localparam int DL  = $clog2(ALIGN_BYTES);
    localparam int PW  = 2 * DN + 1;
    localparam int DM  = (2 ** (DN + DL) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam logic [W-1:0]  USABLE = W'(HEAP_BYTES - ALIGN_BYTES);
    localparam logic [W-1:0]  SPLIT  = W'(HEADER_BYTES * 2);
    localparam logic [CW-1:0] MAXC   = CW'(MAX_FREE);
    localparam logic [PW-1:0] DM_P   = PW'(DM);

    t_state r_st, n_st, r_after, n_after;
    t_req   r_req, n_req;
    t_rsp   r_res, n_res, r_out, n_out;
    logic   r_ov, n_ov, r_merge;
    logic [CW-1:0] r_cnt, n_cnt, r_rd, n_rd, r_ck, n_ck, r_wr, n_wr, r_pos, n_pos;
    logic          r_dv, n_dv;
    logic [W-1:0]  r_left, n_left;
    logic [DN-1:0] r_dx, n_dx, r_dq, n_dq, r_dp, n_dp;
    logic [W-1:0]  r_want, n_want, r_bs, n_bs, r_bz, n_bz, r_gz, n_gz;
    logic [W-1:0]  r_rs, n_rs, r_rz, n_rz, r_ns, n_ns, r_nz, n_nz;
    logic [W-1:0]  r_ps, n_ps, r_pz, n_pz, r_sz, n_sz;
    logic          r_pv, n_pv, r_sv, n_sv, r_relok, n_relok;
    logic [IW-1:0] r_pi, n_pi, r_si, n_si, r_ska, n_ska, r_skb, n_skb;
    logic          r_skav, n_skav, r_skbv, n_skbv;

    logic            t_we;
    logic [IW-1:0]   t_wa, t_ra;
    logic [2*W-1:0]  t_wd, t_rdat;
    logic            s_we;
    logic [SIW-1:0]  s_wa, s_ra;
    logic [W-1:0]    s_wd, s_rdat;

    logic [W-1:0]  d_s, d_z;
    logic [W:0]    d_end, rs_end;
    logic [PW-1:0] w_prod;
    logic [DN-1:0] w_q, w_p;
    logic [W-1:0]  w_m1, w_m2, w_rem;
    logic          issue, sdone, sh_issue, skip;
    t_state        ret_st;

    function automatic logic [W-1:0] sat(input logic [W:0] s);
        return (s > {1'b0, USABLE}) ? USABLE : s[W-1:0];
    endfunction

    bfha_ram #(.WIDTH(2 * W), .DEPTH(MAX_FREE)) u_tbl (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rdat)
    );

    bfha_ram #(.WIDTH(W), .DEPTH(SD)) u_sizes (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rdat)
    );

    assign d_s    = t_rdat[2*W-1:W];
    assign d_z    = t_rdat[W-1:0];
    assign d_end  = {1'b0, d_s} + {1'b0, d_z};
    assign rs_end = {1'b0, r_rs} + {1'b0, r_rz};
    // divide by ALIGN_BYTES through a reciprocal multiply
    assign w_prod = PW'(r_dx) * DM_P;
    assign w_q    = DN'(w_prod >> (DN + DL));
    assign w_p    = DN'(r_dq * DN'(ALIGN_BYTES));
    assign w_m1   = sat({1'b0, r_rz} + {1'b0, (r_pv ? r_pz : W'(0))});
    assign w_m2   = sat({1'b0, w_m1} + {1'b0, (r_sv ? r_sz : W'(0))});
    assign w_rem  = r_bz - r_want;
    assign issue  = (r_rd < r_cnt);
    assign sdone  = !issue && !r_dv;
    assign sh_issue = (r_rd > r_pos);
    assign skip   = (r_skav && r_ck[IW-1:0] == r_ska) || (r_skbv && r_ck[IW-1:0] == r_skb);
    assign ret_st = (r_req.req_type == REQ_FREE) ? S_FFIN : S_AFIN;

    always_comb begin
        n_st = r_st; n_after = r_after; n_req = r_req; n_res = r_res; n_out = r_out;
        n_ov = r_ov; n_cnt = r_cnt; n_rd = r_rd; n_ck = r_ck; n_wr = r_wr; n_pos = r_pos;
        n_dv = r_dv; n_left = r_left; n_dx = r_dx; n_dq = r_dq; n_dp = r_dp;
        n_want = r_want; n_bs = r_bs; n_bz = r_bz; n_gz = r_gz; n_rs = r_rs; n_rz = r_rz;
        n_ns = r_ns; n_nz = r_nz; n_ps = r_ps; n_pz = r_pz; n_sz = r_sz;
        n_pv = r_pv; n_sv = r_sv; n_relok = r_relok; n_pi = r_pi; n_si = r_si;
        n_ska = r_ska; n_skb = r_skb; n_skav = r_skav; n_skbv = r_skbv;
        t_we = 1'b0; t_wa = r_wr[IW-1:0]; t_wd = t_rdat; t_ra = r_rd[IW-1:0];
        s_we = 1'b0; s_wa = r_dq[SIW-1:0]; s_wd = r_gz; s_ra = r_dq[SIW-1:0];
        o_in_stall = (r_st != S_IDLE);

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_st)
            S_INIT: begin
                t_we = 1'b1; t_wa = '0; t_wd = {W'(0), USABLE};
                n_st = S_IDLE;
            end
            S_IDLE: begin
                n_req = i_in_data;
                n_res = '{status: ST_FAIL, grant_addr: '0, granted_bytes: '0,
                          free_bytes: r_left[13:0]};
                if (i_in_valid) begin
                    if (i_in_data.req_type == REQ_ALLOC) begin
                        n_dx = DN'(i_in_data.req_size) +
                               DN'(HEADER_BYTES + ALIGN_BYTES - 1);
                        n_st = S_AQ;
                    end else if (i_in_data.req_addr == '0) begin
                        n_res.status = ST_NULL;
                        n_st = S_DONE;
                    end else if (DN'(i_in_data.req_addr) < DN'(HEADER_BYTES)) begin
                        n_st = S_DONE;
                    end else begin
                        n_dx = DN'(i_in_data.req_addr) - DN'(HEADER_BYTES);
                        n_st = S_FQ;
                    end
                end
            end
            S_AQ: begin n_dq = w_q; n_st = S_AM; end
            S_AM: begin n_dp = w_p; n_st = S_ACHK; end
            S_ACHK: begin
                if (r_req.req_size == '0 || r_dp >= DN'(USABLE)) begin
                    n_st = S_DONE;
                end else begin
                    n_want = r_dp[W-1:0];
                    n_rd = '0; n_dv = 1'b0;
                    n_st = S_FIT;
                end
            end
            S_FIT: begin
                n_rd = issue ? r_rd + 1'b1 : r_rd; n_dv = issue; n_ck = r_rd;
                if (r_dv && d_z >= r_want) begin
                    n_bs = d_s; n_bz = d_z;
                    n_ska = r_ck[IW-1:0]; n_skav = 1'b1; n_skbv = 1'b0;
                    n_rd = '0; n_dv = 1'b0; n_wr = '0;
                    n_after = S_BQ;
                    n_st = S_CMP;
                end else if (sdone) begin
                    n_st = S_DONE;
                end
            end
            S_CMP: begin
                // compact the table, dropping the skipped entries
                n_rd = issue ? r_rd + 1'b1 : r_rd; n_dv = issue; n_ck = r_rd;
                if (r_dv && !skip) begin
                    t_we = 1'b1; t_wa = r_wr[IW-1:0]; t_wd = t_rdat;
                    n_wr = r_wr + 1'b1;
                end
                if (sdone) begin
                    n_cnt = r_wr;
                    n_st = r_after;
                end
            end
            S_BQ: begin
                n_dx = DN'(r_bs);
                n_st = S_ASPL;
            end
            S_ASPL: begin
                n_dq = w_q;
                if (w_rem > SPLIT) begin
                    n_rs = r_bs + r_want; n_rz = w_rem; n_gz = r_want;
                    n_st = S_REL;
                end else begin
                    n_gz = r_bz;
                    n_st = S_AFIN;
                end
            end
            S_AFIN: begin
                s_we = 1'b1;
                n_left = (r_left > r_gz) ? r_left - r_gz : '0;
                n_res.status = ST_OK;
                n_res.grant_addr = 14'(r_bs + W'(HEADER_BYTES));
                n_res.granted_bytes = r_gz[13:0];
                n_res.free_bytes = n_left[13:0];
                n_st = S_DONE;
            end
            S_FQ: begin n_dq = w_q; n_st = S_FM; end
            S_FM: begin n_dp = w_p; n_st = S_FCHK; end
            S_FCHK: begin
                if (r_dp != r_dx || r_dx >= DN'(USABLE)) begin
                    n_st = S_DONE;
                end else begin
                    n_st = S_FRD;
                end
            end
            S_FRD: begin
                n_rs = r_dx[W-1:0]; n_rz = s_rdat;
                n_st = S_REL;
            end
            S_REL: begin
                n_ns = r_rs; n_nz = r_rz;
                n_pv = 1'b0; n_sv = 1'b0;
                n_rd = '0; n_dv = 1'b0;
                n_st = r_merge ? S_ADJ : S_INS;
            end
            S_ADJ: begin
                n_rd = issue ? r_rd + 1'b1 : r_rd; n_dv = issue; n_ck = r_rd;
                if (r_dv) begin
                    if (!r_pv && d_end == {1'b0, r_rs}) begin
                        n_pv = 1'b1; n_pi = r_ck[IW-1:0]; n_ps = d_s; n_pz = d_z;
                    end else if (!r_sv && {1'b0, d_s} == rs_end) begin
                        n_sv = 1'b1; n_si = r_ck[IW-1:0]; n_sz = d_z;
                    end
                end
                if (sdone) begin
                    n_st = S_MRG;
                end
            end
            S_MRG: begin
                if (!r_pv && !r_sv) begin
                    n_st = S_INS;
                end else begin
                    n_ns = r_pv ? r_ps : r_rs;
                    n_nz = w_m2;
                    n_ska = r_pi; n_skav = r_pv; n_skb = r_si; n_skbv = r_sv;
                    n_rd = '0; n_dv = 1'b0; n_wr = '0;
                    n_after = S_INS;
                    n_st = S_CMP;
                end
            end
            S_INS: begin
                if (r_cnt >= MAXC) begin
                    n_relok = 1'b0;
                    n_st = ret_st;
                end else begin
                    n_rd = '0; n_dv = 1'b0;
                    n_st = S_POS;
                end
            end
            S_POS: begin
                n_rd = issue ? r_rd + 1'b1 : r_rd; n_dv = issue; n_ck = r_rd;
                if (r_dv && d_z >= r_nz) begin
                    n_pos = r_ck; n_rd = r_cnt; n_dv = 1'b0;
                    n_st = S_SHF;
                end else if (sdone) begin
                    n_pos = r_cnt; n_rd = r_cnt; n_dv = 1'b0;
                    n_st = S_SHF;
                end
            end
            S_SHF: begin
                // move entries pos..cnt-1 up by one, top first
                t_ra = IW'(r_rd - 1'b1);
                n_rd = sh_issue ? r_rd - 1'b1 : r_rd; n_dv = sh_issue; n_ck = r_rd;
                if (r_dv) begin
                    t_we = 1'b1; t_wa = r_ck[IW-1:0]; t_wd = t_rdat;
                end
                if (!sh_issue && !r_dv) begin
                    n_st = S_PUT;
                end
            end
            S_PUT: begin
                t_we = 1'b1; t_wa = r_pos[IW-1:0]; t_wd = {r_ns, r_nz};
                n_cnt = r_cnt + 1'b1;
                n_relok = 1'b1;
                n_st = ret_st;
            end
            S_FFIN: begin
                if (r_relok) begin
                    n_left = sat({1'b0, r_left} + {1'b0, r_rz});
                    n_res.status = ST_OK;
                    n_res.granted_bytes = r_rz[13:0];
                    n_res.free_bytes = n_left[13:0];
                end else begin
                    n_res.status = ST_FULL;
                end
                n_st = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov = 1'b1;
                    n_out = r_res;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT;
            r_ov <= 1'b0;
            r_cnt <= CW'(1);
            r_left <= USABLE;
            r_merge <= 1'b0;
            r_dv <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
            r_cnt <= n_cnt;
            r_left <= n_left;
            r_dv <= n_dv;
            if (i_cfg_we) begin
                r_merge <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_after <= n_after; r_req <= n_req; r_res <= n_res; r_out <= n_out;
        r_rd <= n_rd; r_ck <= n_ck; r_wr <= n_wr; r_pos <= n_pos;
        r_dx <= n_dx; r_dq <= n_dq; r_dp <= n_dp;
        r_want <= n_want; r_bs <= n_bs; r_bz <= n_bz; r_gz <= n_gz;
        r_rs <= n_rs; r_rz <= n_rz; r_ns <= n_ns; r_nz <= n_nz;
        r_ps <= n_ps; r_pz <= n_pz; r_sz <= n_sz;
        r_pv <= n_pv; r_sv <= n_sv; r_relok <= n_relok; r_pi <= n_pi; r_si <= n_si;
        r_ska <= n_ska; r_skb <= n_skb; r_skav <= n_skav; r_skbv <= n_skbv;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // the list may be empty when one allocate takes the whole heap
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAXC)
        else $error("free list count out of range");
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= USABLE)
        else $error("free byte count above usable heap");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while one is in flight");
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_st == S_DONE))
        else $error("response raised outside the done state");
`endif
endmodule

[dv/tb_top.sv]
// Self-checking testbench for the best-fit heap allocator: directed and random requests.
`timescale 1ns / 100ps

module tb_top;
    import bfha_pkg::*;

    localparam int USABLE  = 16376;
    localparam int HDR     = 8;
    localparam int ALN     = 8;
    localparam int NFREE   = 32;
    localparam int SPLIT   = 2 * HDR;
    localparam int DEPTH   = 2048;
    localparam int SETTLE  = 250;
    localparam int WD_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_rsp o_out_data;
    logic i_cfg_we = 1'b0;
    logic i_cfg_data = 1'b0;

    always #6 i_clk = ~i_clk;

    best_fit_heap_allocator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // heap state mirror
    int fl_start[NFREE];
    int fl_size[NFREE];
    int fl_count;
    int bytes_left;
    int blk_size[DEPTH];
    bit merge_on;

    int live_q[$];      // payload addresses currently allocated
    int ever_q[$];      // every payload address ever granted
    t_rsp pending_rsp_q[$];

    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_ok = 0;
    bit idle_on = 1'b1;
    int hold_cnt = 0;
    int burst_cnt = 0;
    int quiet_cycles = 0;

    function automatic int sat_add(int a, int b);
        return (a + b > USABLE) ? USABLE : a + b;
    endfunction

    function automatic void fl_remove(int idx);
        if (idx >= fl_count) return;
        for (int k = idx; k + 1 < fl_count; k++) begin
            fl_start[k] = fl_start[k + 1];
            fl_size[k]  = fl_size[k + 1];
        end
        fl_count--;
    endfunction

    function automatic bit fl_insert(int start, int size);
        int pos;
        pos = 0;
        if (fl_count >= NFREE) return 1'b0;
        while (pos < fl_count && fl_size[pos] < size) pos++;
        for (int k = fl_count; k > pos; k--) begin
            fl_start[k] = fl_start[k - 1];
            fl_size[k]  = fl_size[k - 1];
        end
        fl_start[pos] = start;
        fl_size[pos]  = size;
        fl_count++;
        return 1'b1;
    endfunction

    // reinsert a block, coalescing with touching neighbors when enabled
    function automatic bit give_back(int start, int size);
        int pred, succ, ns, nz;
        pred = NFREE;
        succ = NFREE;
        ns = start;
        nz = size;
        if (merge_on) begin
            for (int i = 0; i < fl_count; i++) begin
                if (pred == NFREE && fl_start[i] + fl_size[i] == start) pred = i;
                else if (succ == NFREE && fl_start[i] == start + size) succ = i;
            end
        end
        if (pred == NFREE && succ == NFREE) return fl_insert(start, size);
        if (pred != NFREE) begin
            ns = fl_start[pred];
            nz = sat_add(nz, fl_size[pred]);
        end
        if (succ != NFREE) nz = sat_add(nz, fl_size[succ]);
        if (pred != NFREE && succ != NFREE) begin
            if (pred > succ) begin
                fl_remove(pred);
                fl_remove(succ);
            end else begin
                fl_remove(succ);
                fl_remove(pred);
            end
        end else if (pred != NFREE) begin
            fl_remove(pred);
        end else begin
            fl_remove(succ);
        end
        return fl_insert(ns, nz);
    endfunction

    function automatic t_rsp predict_heap_rsp(t_req r);
        t_rsp e;
        int want, i, bs, bz, addr;
        e = '0;
        e.status = ST_FAIL;
        if (r.req_type == REQ_ALLOC) begin
            if (r.req_size != 0) begin
                want = int'(r.req_size) + HDR;
                if (want % ALN != 0) want += ALN - want % ALN;
                if (want < USABLE) begin
                    i = 0;
                    while (i < fl_count && fl_size[i] < want) i++;
                    if (i < fl_count) begin
                        bs = fl_start[i];
                        bz = fl_size[i];
                        fl_remove(i);
                        if (bz - want > SPLIT) begin
                            void'(give_back(bs + want, bz - want));
                            bz = want;
                        end
                        bytes_left = (bytes_left > bz) ? bytes_left - bz : 0;
                        blk_size[(bs / ALN) % DEPTH] = bz;
                        e.status = ST_OK;
                        e.grant_addr = 14'(bs + HDR);
                        e.granted_bytes = 14'(bz);
                        live_q.push_back(bs + HDR);
                        if (blk_size[(bs / ALN) % DEPTH] == bz && !(bs + HDR inside {ever_q}))
                            ever_q.push_back(bs + HDR);
                    end
                end
            end
        end else begin
            addr = int'(r.req_addr);
            if (addr == 0) begin
                e.status = ST_NULL;
            end else if (addr >= HDR) begin
                bs = addr - HDR;
                if (bs % ALN == 0 && bs < USABLE) begin
                    bz = blk_size[(bs / ALN) % DEPTH];
                    if (give_back(bs, bz)) begin
                        bytes_left = sat_add(bytes_left, bz);
                        e.status = ST_OK;
                        e.granted_bytes = 14'(bz);
                        foreach (live_q[k]) if (live_q[k] == addr) begin
                            live_q.delete(k);
                            break;
                        end
                    end else begin
                        e.status = ST_FULL;
                    end
                end
            end
        end
        e.free_bytes = 14'(bytes_left);
        return e;
    endfunction

    // drive one request, wait for its transaction, record the prediction
    task automatic send_req(logic kind, int size, int addr);
        t_req r;
        int gap;
        r.req_type = kind;
        r.req_size = 16'(size);
        r.req_addr = 14'(addr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        pending_rsp_q.push_back(predict_heap_rsp(r));
        n_sent++;
    endtask

    task automatic do_alloc(int size);
        send_req(REQ_ALLOC, size, 0);
    endtask

    task automatic do_free(int addr);
        send_req(REQ_FREE, 0, addr);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_merge(bit v);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        merge_on = v;
    endtask

    // response checker
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            quiet_cycles <= 0;
            if (pending_rsp_q.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_out_data);
                errors++;
            end else begin
                e = pending_rsp_q.pop_front();
                n_checked++;
                if (e.status == ST_FULL) n_full++;
                if (e.status == ST_OK) n_ok++;
                if (o_out_data.status !== e.status)
                    $display("%0t: status exp %0d got %0d", $time, e.status,
                             o_out_data.status);
                if (o_out_data.grant_addr !== e.grant_addr)
                    $display("%0t: grant_addr exp %0d got %0d", $time, e.grant_addr,
                             o_out_data.grant_addr);
                if (o_out_data.granted_bytes !== e.granted_bytes)
                    $display("%0t: granted_bytes exp %0d got %0d", $time,
                             e.granted_bytes, o_out_data.granted_bytes);
                if (o_out_data.free_bytes !== e.free_bytes)
                    $display("%0t: free_bytes exp %0d got %0d", $time, e.free_bytes,
                             o_out_data.free_bytes);
                if (o_out_data !== e) errors++;
            end
        end else if (i_rst_n && i_in_valid && !o_in_stall) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WD_LIMIT) begin
            $display("%0t: watchdog expired, %0d responses outstanding", $time,
                     pending_rsp_q.size());
            $display("best_fit_heap_allocator regression: fail");
            $finish;
        end
    end

    // receiver stall: long hold on request, random bursts otherwise while idle_on is set
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            i_out_stall <= 1'b1;
            hold_cnt--;
        end else if (burst_cnt > 0) begin
            i_out_stall <= 1'b1;
            burst_cnt--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            burst_cnt = $urandom_range(0, 5);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic int pick_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return $urandom_range(1, 256);
        if (p < 90) return $urandom_range(257, 4096);
        if (p < 96) return $urandom_range(0, 65535);
        return 0;
    endfunction

    task automatic random_req();
        int p;
        p = $urandom_range(0, 99);
        if (live_q.size() != 0 && p < 45) begin
            do_free(live_q[$urandom_range(0, live_q.size() - 1)]);
        end else if (p < 47 && ever_q.size() != 0) begin
            do_free(ever_q[$urandom_range(0, ever_q.size() - 1)]);   // possibly a double free
        end else if (p < 50) begin
            case ($urandom_range(0, 2))
                0: do_free(0);
                1: do_free($urandom_range(1, HDR - 1));
                default: do_free(($urandom_range(0, 16383) & ~(ALN - 1)) | $urandom_range(1, 7));
            endcase
        end else begin
            do_alloc(pick_size());
        end
    endtask

    task automatic test_directed();
        write_merge(1'b0);
        do_alloc(0);
        do_alloc(65535);
        do_alloc(16368);            // rounds to the usable size: rejected
        do_alloc(16360);            // takes the whole heap
        do_alloc(1);                // no fit
        do_free(HDR);
        do_free(0);
        do_free(4);
        do_free(13);
        do_alloc(1);
        do_alloc(7);
        do_alloc(9);
        do_free(HDR);
        do_free(HDR);               // double free
        do_free(16383);
        do_alloc(16);
        do_alloc(1);
    endtask

    task automatic test_merge();
        int a, b, c;
        write_merge(1'b1);
        while (live_q.size() != 0) do_free(live_q[0]);
        do_alloc(24);
        a = live_q[$];
        do_alloc(40);
        b = live_q[$];
        do_alloc(24);
        c = live_q[$];
        do_alloc(100);
        do_free(a);
        do_free(c);
        do_free(b);                 // merges on both sides
        while (live_q.size() != 0) do_free(live_q[0]);
    endtask

    task automatic test_table_full();
        write_merge(1'b0);
        repeat (72) do_alloc($urandom_range(1, 8));
        for (int k = 0; k < live_q.size(); k++) do_free(live_q[k]);
        write_merge(1'b1);
        while (live_q.size() != 0) do_free(live_q[0]);
    endtask

    task automatic test_backpressure();
        drain();
        hold_cnt = 400;
        repeat (12) random_req();
        drain();                    // sender pauses until all responses are in
        repeat (8) random_req();
    endtask

    task automatic test_random(int count, bit merge_val);
        write_merge(merge_val);
        repeat (count) random_req();
    endtask

    initial begin
        foreach (blk_size[k]) blk_size[k] = 0;
        foreach (fl_start[k]) begin
            fl_start[k] = 0;
            fl_size[k] = 0;
        end
        fl_size[0] = USABLE;
        fl_count = 1;
        bytes_left = USABLE;
        merge_on = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_merge();
        test_table_full();
        test_backpressure();
        test_random(180, 1'b1);
        test_random(140, 1'b0);
        test_random(140, 1'b1);
        drain();
        idle_on = 1'b0;
        test_random(100, 1'b0);
        drain();

        $display("covered %0d requests, %0d checked: %0d ok, %0d table-full", n_sent,
                 n_checked, n_ok, n_full);
        $display("merge on and off, long output hold, and idle gaps on both sides");
        if (errors == 0 && pending_rsp_q.size() == 0) begin
            $display("best_fit_heap_allocator regression: pass");
        end else begin
            $display("best_fit_heap_allocator regression: fail");
        end
        $finish;
    end

endmodule

[best_fit_heap_allocator.f]
rtl/core/bfha_pkg.sv
rtl/core/bfha_ram.sv
rtl/core/best_fit_heap_allocator.sv
dv/tb_top.sv
